@@ design/stl_pkg.sv @@
// Shared constants for the segmented trie route lookup block.
package stl_pkg;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;
    localparam int HOP_W  = 8;

    localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

endpackage

@@ design/stl_if.sv @@
// Request and response channel interfaces of the route lookup block.
interface stl_req_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [stl_pkg::ADDR_W-1:0]    address;
    logic [stl_pkg::LEN_W-1:0]     prefix_len;
    logic [stl_pkg::HOP_W-1:0]     next_hop;

    modport source (output valid, kind, address, prefix_len, next_hop, input ready);
    modport sink (input valid, kind, address, prefix_len, next_hop, output ready);
endinterface

interface stl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [stl_pkg::HOP_W-1:0]     hop_out;
    logic                          pool_full;

    modport source (output valid, found, hop_out, pool_full, input ready);
    modport sink (input valid, found, hop_out, pool_full, output ready);
endinterface

@@ design/stl_ram.sv @@
// Simple dual-port memory with one write port and one registered read port.
module stl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/segmented_trie_ip_lookup_top.sv @@
// Top level of the segmented binary trie longest-prefix-match route table.
// After reset the segment table is swept, one entry a cycle; not ready until the sweep ends.
// Lookup: segment read, then one node read per trie level visited, at most 32-SEGMENT_BITS+1.
// Short add: the 2**(SEGMENT_BITS-len) covered segments are read, rewritten if empty or shorter.
// Long add: the root is loaded or made, then each trie level below the segment is walked.
// One word in flight; the result waits in an output register while the next word is taken.
module segmented_trie_ip_lookup_top #(
    parameter int SEGMENT_BITS = 16,
    parameter int NODE_COUNT   = 4096,
    parameter int HOP_BITS     = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    stl_req_if.sink      i_req,
    stl_rsp_if.source    o_rsp
);

    localparam int SB  = SEGMENT_BITS;
    localparam int TB  = stl_pkg::ADDR_W - SEGMENT_BITS;
    localparam int NB  = $clog2(NODE_COUNT);
    localparam int NFW = NB + 1;
    localparam int LW  = $clog2(SEGMENT_BITS + 1);
    localparam int TBW = $clog2(TB + 1);
    localparam int HW  = HOP_BITS;

    localparam logic [HW:0]    EMPTY_HOP = {1'b1, {HW{1'b0}}};
    localparam logic [NFW-1:0] POOL_END  = NFW'(NODE_COUNT);

    typedef struct packed {
        logic [NB-1:0] root;
        logic [HW:0]   hop;
        logic [LW-1:0] len;
    } t_seg;

    typedef struct packed {
        logic [NB-1:0] left;
        logic [NB-1:0] right;
        logic [HW:0]   hop;
    } t_node;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_LSEG, ST_LNODE, ST_SWR,
        ST_ASEG, ST_AROOT, ST_ASTEP, ST_ANEW, ST_ALOAD, ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic [SB-1:0]              r_clr, n_clr;
    logic [NFW-1:0]             r_free, n_free;
    logic [stl_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic [stl_pkg::LEN_W-1:0]  r_len, n_len;
    logic [HW:0]                r_hop, n_hop;
    logic [SB-1:0]              r_sidx, n_sidx;
    logic [SB-1:0]              r_slast, n_slast;
    logic [TB-1:0]              r_path, n_path;
    logic [TBW-1:0]             r_rem, n_rem;
    logic [HW:0]                r_best, n_best;
    logic [HW:0]                r_direct, n_direct;
    logic [NB-1:0]              r_cur, n_cur;
    t_node                      r_node, n_node;
    logic                       r_res_found, n_res_found;
    logic [stl_pkg::HOP_W-1:0]  r_res_hop, n_res_hop;
    logic                       r_res_full, n_res_full;
    logic                       r_out_valid, n_out_valid;
    logic                       r_found, n_found;
    logic [stl_pkg::HOP_W-1:0]  r_hop_out, n_hop_out;
    logic                       r_full, n_full;

    logic          seg_we, seg_re;
    logic [SB-1:0] seg_waddr, seg_raddr;
    t_seg          seg_wdata, seg_q;
    logic          node_we, node_re;
    logic [NB-1:0] node_waddr, node_raddr;
    t_node         node_wdata, node_q;

    logic [stl_pkg::LEN_W-1:0] in_len;
    logic [SB-1:0]             in_seg, in_mask;
    logic                      in_short;
    logic [HW:0]               node_best, final_hop;
    logic [NB-1:0]             child;
    logic                      pool_out;

    stl_ram #(.WIDTH($bits(t_seg)), .DEPTH(2**SEGMENT_BITS)) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (seg_we),
        .i_waddr (seg_waddr),
        .i_wdata (seg_wdata),
        .i_re    (seg_re),
        .i_raddr (seg_raddr),
        .o_rdata (seg_q)
    );

    stl_ram #(.WIDTH($bits(t_node)), .DEPTH(NODE_COUNT)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_re    (node_re),
        .i_raddr (node_raddr),
        .o_rdata (node_q)
    );

    assign i_req.ready     = (r_state == ST_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.found     = r_found;
    assign o_rsp.hop_out   = r_hop_out;
    assign o_rsp.pool_full = r_full;

    assign in_len    = (i_req.prefix_len > stl_pkg::MAX_LEN) ? stl_pkg::MAX_LEN
                                                            : i_req.prefix_len;
    assign in_seg    = i_req.address[stl_pkg::ADDR_W-1 -: SB];
    assign in_short  = (i_req.kind == stl_pkg::KIND_ADD) &&
                       (in_len <= stl_pkg::LEN_W'(SEGMENT_BITS));
    assign in_mask   = in_short ? ({SB{1'b1}} >> in_len) : '0;
    assign node_best = node_q.hop[HW] ? r_best : node_q.hop;
    assign final_hop = node_best[HW] ? r_direct : node_best;
    assign child     = r_path[TB-1] ? r_node.right : r_node.left;
    assign pool_out  = (r_free >= POOL_END);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_free      = r_free;
        n_addr      = r_addr;
        n_len       = r_len;
        n_hop       = r_hop;
        n_sidx      = r_sidx;
        n_slast     = r_slast;
        n_path      = r_path;
        n_rem       = r_rem;
        n_best      = r_best;
        n_direct    = r_direct;
        n_cur       = r_cur;
        n_node      = r_node;
        n_res_found = r_res_found;
        n_res_hop   = r_res_hop;
        n_res_full  = r_res_full;
        n_out_valid = r_out_valid;
        n_found     = r_found;
        n_hop_out   = r_hop_out;
        n_full      = r_full;
        seg_we      = 1'b0;
        seg_waddr   = r_sidx;
        seg_wdata   = seg_q;
        seg_re      = 1'b0;
        seg_raddr   = r_sidx;
        node_we     = 1'b0;
        node_waddr  = r_cur;
        node_wdata  = r_node;
        node_re     = 1'b0;
        node_raddr  = child;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                seg_we    = 1'b1;
                seg_waddr = r_clr;
                seg_wdata = '{root: '0, hop: EMPTY_HOP, len: '0};
                n_clr     = r_clr + 1'b1;
                if (r_clr == {SB{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_addr      = i_req.address;
                    n_len       = in_len;
                    n_hop       = {1'b0, HW'(i_req.next_hop)};
                    n_sidx      = in_seg & ~in_mask;
                    n_slast     = in_seg | in_mask;
                    n_res_found = 1'b0;
                    n_res_hop   = '0;
                    n_res_full  = 1'b0;
                    seg_re      = 1'b1;
                    seg_raddr   = in_seg & ~in_mask;
                    if (i_req.kind == stl_pkg::KIND_LOOKUP) begin
                        n_state = ST_LSEG;
                    end else if (in_short) begin
                        n_state = ST_SWR;
                    end else begin
                        n_state = ST_ASEG;
                    end
                end
            end
            ST_LSEG: begin
                n_direct = seg_q.hop;
                n_best   = EMPTY_HOP;
                n_path   = r_addr[TB-1:0];
                n_rem    = TBW'(TB);
                if (seg_q.root == '0) begin
                    n_res_found = ~seg_q.hop[HW];
                    n_res_hop   = seg_q.hop[HW] ? '0 : stl_pkg::HOP_W'(seg_q.hop[HW-1:0]);
                    n_state     = ST_DONE;
                end else begin
                    node_re    = 1'b1;
                    node_raddr = seg_q.root;
                    n_state    = ST_LNODE;
                end
            end
            ST_LNODE: begin
                n_best = node_best;
                if (r_rem == '0 ||
                    (r_path[TB-1] ? node_q.right : node_q.left) == '0) begin
                    n_res_found = ~final_hop[HW];
                    n_res_hop   = final_hop[HW] ? '0 : stl_pkg::HOP_W'(final_hop[HW-1:0]);
                    n_state     = ST_DONE;
                end else begin
                    node_re    = 1'b1;
                    node_raddr = r_path[TB-1] ? node_q.right : node_q.left;
                    n_path     = r_path << 1;
                    n_rem      = r_rem - 1'b1;
                end
            end
            ST_SWR: begin
                if (seg_q.hop[HW] || (r_len > stl_pkg::LEN_W'(seg_q.len))) begin
                    seg_we    = 1'b1;
                    seg_waddr = r_sidx;
                    seg_wdata = '{root: seg_q.root, hop: r_hop, len: LW'(r_len)};
                end
                if (r_sidx == r_slast) begin
                    n_state = ST_DONE;
                end else begin
                    n_sidx    = r_sidx + 1'b1;
                    seg_re    = 1'b1;
                    seg_raddr = r_sidx + 1'b1;
                end
            end
            ST_ASEG: begin
                n_path = r_addr[TB-1:0];
                n_rem  = TBW'(r_len - stl_pkg::LEN_W'(SEGMENT_BITS));
                if (seg_q.root == '0) begin
                    if (pool_out) begin
                        n_res_full = 1'b1;
                        n_state    = ST_DONE;
                    end else begin
                        n_cur      = r_free[NB-1:0];
                        n_node     = '{left: '0, right: '0, hop: EMPTY_HOP};
                        n_free     = r_free + 1'b1;
                        node_we    = 1'b1;
                        node_waddr = r_free[NB-1:0];
                        node_wdata = '{left: '0, right: '0, hop: EMPTY_HOP};
                        seg_we     = 1'b1;
                        seg_waddr  = r_sidx;
                        seg_wdata  = '{root: r_free[NB-1:0], hop: seg_q.hop, len: seg_q.len};
                        n_state    = ST_ASTEP;
                    end
                end else begin
                    node_re    = 1'b1;
                    node_raddr = seg_q.root;
                    n_cur      = seg_q.root;
                    n_state    = ST_AROOT;
                end
            end
            ST_AROOT: begin
                n_node  = node_q;
                n_state = ST_ASTEP;
            end
            ST_ASTEP: begin
                n_path = r_path << 1;
                n_rem  = r_rem - 1'b1;
                if (child == '0) begin
                    if (pool_out) begin
                        n_res_full = 1'b1;
                        n_state    = ST_DONE;
                    end else begin
                        node_we = 1'b1;
                        if (r_path[TB-1]) begin
                            node_wdata.right = r_free[NB-1:0];
                        end else begin
                            node_wdata.left = r_free[NB-1:0];
                        end
                        n_cur   = r_free[NB-1:0];
                        n_free  = r_free + 1'b1;
                        n_state = ST_ANEW;
                    end
                end else begin
                    node_re = 1'b1;
                    n_cur   = child;
                    n_state = ST_ALOAD;
                end
            end
            ST_ANEW: begin
                node_we    = 1'b1;
                node_wdata = '{left: '0, right: '0, hop: (r_rem == '0) ? r_hop : EMPTY_HOP};
                n_node     = node_wdata;
                n_state    = (r_rem == '0) ? ST_DONE : ST_ASTEP;
            end
            ST_ALOAD: begin
                n_node = node_q;
                if (r_rem == '0) begin
                    if (node_q.hop[HW]) begin
                        node_we    = 1'b1;
                        node_wdata = '{left: node_q.left, right: node_q.right, hop: r_hop};
                    end
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_ASTEP;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_found     = r_res_found;
                    n_hop_out   = r_res_hop;
                    n_full      = r_res_full;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_free      <= NFW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
        r_addr      <= n_addr;
        r_len       <= n_len;
        r_hop       <= n_hop;
        r_sidx      <= n_sidx;
        r_slast     <= n_slast;
        r_path      <= n_path;
        r_rem       <= n_rem;
        r_best      <= n_best;
        r_direct    <= n_direct;
        r_cur       <= n_cur;
        r_node      <= n_node;
        r_res_found <= n_res_found;
        r_res_hop   <= n_res_hop;
        r_res_full  <= n_res_full;
        r_found     <= n_found;
        r_hop_out   <= n_hop_out;
        r_full      <= n_full;
    end

`ifndef NO_ASSERTIONS
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free != '0 && r_free <= POOL_END)
        else $error("node pool pointer out of range");

    a_free_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_free >= $past(r_free))
        else $error("node pool pointer moved back");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_found |-> r_hop_out == '0)
        else $error("hop reported without a match");

    a_full_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_found && r_full))
        else $error("match and pool full on one word");
`endif

endmodule
